>>> sv/slfl_pkg.sv
// Shared types and constants for the sync/length frame loader.
package slfl_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned WCNT_W  = 14;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_END   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FAULT = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_NEWEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_OLDER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BASE   = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_NEWEST_RST = 8'hC0;
  localparam logic [BYTE_W-1:0] SYNC_OLDER_RST  = 8'hDE;
  localparam logic [WORD_W-1:0] LOAD_BASE_RST   = 32'h0000_1000;

  typedef struct packed {
    logic               word_write;
    logic [WORD_W-1:0]  word_address;
    logic [WORD_W-1:0]  word_data;
    logic [PHASE_W-1:0] phase;
  } result_t;

endpackage

>>> sv/sync_length_frame_loader_unit.sv
// Frame loader: hunts a sync pair, reads a length, packs payload bytes into word writes.
//
// Usage:
//   Input channel: one received byte per transaction on in_rx_byte (in_valid/in_stall).
//   Result channel: one result per byte: out_word_write flags a completed 32-bit
//   payload word at out_word_address (base + 4 * word index), first byte in
//   bits 31..24; out_phase gives the phase after that byte (hunt, length,
//   payload, end sync, done, fault). Done and fault are sticky until reset.
//   Config port: cfg_we writes register cfg_index (0 sync newest, 1 sync older,
//   2 load base address) from cfg_wdata; write only while the block is idle.
// Timing:
//   The result is registered: the per-byte state update sits between the input and
//   the output register. Throughput is one byte per cycle while in_stall is low, set by
//   the single state update per byte.
//   When the receiver stalls, one more result is parked in a skid register;
//   in_stall rises only once that skid register is full.
// Reset (rst_n low, synchronous): phase returns to hunt, all counters clear,
//   config registers take their default values, both channels empty.
module sync_length_frame_loader_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [slfl_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_word_write,
  output logic [slfl_pkg::WORD_W-1:0]         out_word_address,
  output logic [slfl_pkg::WORD_W-1:0]         out_word_data,
  output logic [slfl_pkg::PHASE_W-1:0]        out_phase,
  input  logic                                cfg_we,
  input  logic [slfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slfl_pkg::WORD_W-1:0]         cfg_wdata
);

  logic [slfl_pkg::BYTE_W-1:0]  sync_newest_r;
  logic [slfl_pkg::BYTE_W-1:0]  sync_older_r;
  logic [slfl_pkg::WORD_W-1:0]  load_base_r;

  logic [slfl_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [slfl_pkg::BYTE_W-1:0]  prev_byte_r, prev_byte_nxt;
  logic [slfl_pkg::BYTE_W-1:0]  len_low_r, len_low_nxt;
  logic [slfl_pkg::LEN_W-1:0]   pay_len_r, pay_len_nxt;
  logic [slfl_pkg::LEN_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [1:0]                   lane_r, lane_nxt;
  logic [slfl_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [slfl_pkg::WCNT_W-1:0]  word_cnt_r, word_cnt_nxt;

  slfl_pkg::result_t res_nxt, out_r, skid_r;
  logic out_v_r, skid_v_r;
  logic in_acc, out_take;
  logic [slfl_pkg::LEN_W-1:0] byte_cnt_inc;
  logic [slfl_pkg::ACC_W-1:0] lane_bits;

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !skid_v_r;
  assign out_take = out_v_r && !out_stall;

  assign byte_cnt_inc = byte_cnt_r + slfl_pkg::LEN_W'(1);

  always_comb begin
    unique case (lane_r)
      2'd3:    lane_bits = {in_rx_byte, 16'h0000};
      2'd2:    lane_bits = {8'h00, in_rx_byte, 8'h00};
      default: lane_bits = {16'h0000, in_rx_byte};
    endcase
  end

  // per-byte state update
  always_comb begin
    phase_nxt     = phase_r;
    prev_byte_nxt = prev_byte_r;
    len_low_nxt   = len_low_r;
    pay_len_nxt   = pay_len_r;
    byte_cnt_nxt  = byte_cnt_r;
    lane_nxt      = lane_r;
    acc_nxt       = acc_r;
    word_cnt_nxt  = word_cnt_r;
    res_nxt       = '0;
    unique case (phase_r)
      slfl_pkg::PH_HUNT: begin
        if (in_rx_byte == sync_newest_r && prev_byte_r == sync_older_r) begin
          phase_nxt    = slfl_pkg::PH_LEN;
          byte_cnt_nxt = '0;
          lane_nxt     = 2'd3;
          acc_nxt      = '0;
          word_cnt_nxt = '0;
        end
        prev_byte_nxt = in_rx_byte;
      end
      slfl_pkg::PH_LEN: begin
        if (byte_cnt_r == '0) begin
          len_low_nxt  = in_rx_byte;
          byte_cnt_nxt = slfl_pkg::LEN_W'(1);
        end else begin
          pay_len_nxt  = {in_rx_byte, len_low_r};
          byte_cnt_nxt = '0;
          phase_nxt    = slfl_pkg::PH_DATA;
        end
        prev_byte_nxt = in_rx_byte;
      end
      slfl_pkg::PH_DATA: begin
        if (lane_r == 2'd0) begin
          res_nxt.word_write   = 1'b1;
          res_nxt.word_data    = {acc_r, in_rx_byte};
          res_nxt.word_address = load_base_r
                                 + slfl_pkg::WORD_W'({word_cnt_r, 2'b00});
          word_cnt_nxt = word_cnt_r + slfl_pkg::WCNT_W'(1);
          acc_nxt      = '0;
          lane_nxt     = 2'd3;
        end else begin
          acc_nxt  = acc_r | lane_bits;
          lane_nxt = lane_r - 2'd1;
        end
        // a zero length wraps the counter, giving 65536 bytes
        if (byte_cnt_inc == pay_len_r) begin
          phase_nxt    = slfl_pkg::PH_END;
          byte_cnt_nxt = '0;
        end else begin
          byte_cnt_nxt = byte_cnt_inc;
        end
      end
      slfl_pkg::PH_END: begin
        if (byte_cnt_r == '0) begin
          byte_cnt_nxt = slfl_pkg::LEN_W'(1);
        end else begin
          byte_cnt_nxt = '0;
          if (in_rx_byte == sync_newest_r && prev_byte_r == sync_older_r) begin
            phase_nxt = slfl_pkg::PH_DONE;
          end else begin
            phase_nxt = slfl_pkg::PH_FAULT;
          end
        end
        prev_byte_nxt = in_rx_byte;
      end
      slfl_pkg::PH_DONE, slfl_pkg::PH_FAULT: begin
      end
      default: phase_nxt = slfl_pkg::PH_FAULT;
    endcase
    res_nxt.phase = phase_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_newest_r <= slfl_pkg::SYNC_NEWEST_RST;
      sync_older_r  <= slfl_pkg::SYNC_OLDER_RST;
      load_base_r   <= slfl_pkg::LOAD_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slfl_pkg::CFG_SYNC_NEWEST: sync_newest_r <= cfg_wdata[slfl_pkg::BYTE_W-1:0];
        slfl_pkg::CFG_SYNC_OLDER:  sync_older_r  <= cfg_wdata[slfl_pkg::BYTE_W-1:0];
        slfl_pkg::CFG_LOAD_BASE:   load_base_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= slfl_pkg::PH_HUNT;
      prev_byte_r <= '0;
      len_low_r   <= '0;
      pay_len_r   <= '0;
      byte_cnt_r  <= '0;
      lane_r      <= 2'd3;
      acc_r       <= '0;
      word_cnt_r  <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      prev_byte_r <= prev_byte_nxt;
      len_low_r   <= len_low_nxt;
      pay_len_r   <= pay_len_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      lane_r      <= lane_nxt;
      acc_r       <= acc_nxt;
      word_cnt_r  <= word_cnt_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_take) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_v_r || out_take) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (!out_v_r || out_take) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_word_write   = out_r.word_write;
  assign out_word_address = out_r.word_address;
  assign out_word_data    = out_r.word_data;
  assign out_phase        = out_r.phase;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.word_write) |->
      (out_r.phase == slfl_pkg::PH_DATA || out_r.phase == slfl_pkg::PH_END))
    else $error("word write outside payload");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.word_write) |->
      (out_r.word_address == '0 && out_r.word_data == '0))
    else $error("non-write result carries address or data");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == slfl_pkg::PH_DONE) |=> (phase_r == slfl_pkg::PH_DONE))
    else $error("left done state");

  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == slfl_pkg::PH_FAULT) |=> (phase_r == slfl_pkg::PH_FAULT))
    else $error("left fault state");

endmodule
